>>> design/lhogs_pkg.sv
// Shared constants, types and helpers for the order-m log-spacings block.
package lhogs_pkg;

   localparam int MaxSamples = 256;
   localparam int FracBits   = 16;
   localparam int SampleW    = FracBits + 1;
   localparam int AddrW      = $clog2(MaxSamples);
   localparam int CountW     = AddrW + 1;
   localparam int LogFrac    = 26;
   localparam int KW         = 5;
   localparam int XW         = 31;

   localparam logic [SampleW-1:0] OneVal = SampleW'(1) << FracBits;
   localparam logic [31:0]        Ln2Q32 = 32'hB172_17F8;

   localparam logic [1:0] StatusOk       = 2'd0;
   localparam logic [1:0] StatusOrder    = 2'd1;
   localparam logic [1:0] StatusFew      = 2'd2;
   localparam logic [1:0] StatusZeroGap  = 2'd3;

   localparam logic RegGapOrder = 1'b0;
   localparam logic RegCritical = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRD, ST_SGET, ST_SRDJ, ST_SCMP, ST_SPUT,
      ST_LRD, ST_LGAP, ST_LSQ, ST_LMUL, ST_LACC, ST_FIN
   } back_state_type;

   typedef struct packed {
      logic              valid;
      logic [CountW-1:0] n;
   } job_type;

   typedef struct packed {
      logic               en;
      logic [AddrW-1:0]   addr;
      logic [SampleW-1:0] data;
   } ram_wr_type;

   // position of the leading one of a gap
   function automatic logic [KW-1:0] lead_one(input logic [SampleW-1:0] g);
      logic [KW-1:0] k;
      k = '0;
      for (int b = 0; b < SampleW; b++) begin
         if (g[b]) k = KW'(b);
      end
      return k;
   endfunction

endpackage

>>> design/log_high_order_gap_statistic.sv
// Top level of the order-m log-spacings statistic block.
// Samples load at one word per cycle; input stalls from the last sample until the set is done.
// Sort: insertion sort in the sample RAM.
// Log pass: 26 squarings per gap in one 31x31 multiplier, n+2-m gaps.
// Result is registered; the next set may load while it waits.
// Synchronous active-high reset clears control state; the sample RAM needs no clearing.
module log_high_order_gap_statistic (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [23:0] req_sample,
   input  logic               req_last_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_statistic,
   output logic               rsp_reject,
   output logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [8:0]  gap_order_ff;
   logic [31:0] critical_ff;
   logic        back_busy, job_pop;
   lhogs_pkg::job_type    job;
   lhogs_pkg::ram_wr_type front_wr, back_wr, ram_wr;
   logic [lhogs_pkg::AddrW-1:0]   rd_addr_a, rd_addr_b;
   logic [lhogs_pkg::SampleW-1:0] rd_data_a, rd_data_b;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == lhogs_pkg::RegCritical) ? critical_ff
                                                                : {23'b0, gap_order_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_order_ff <= 9'd2;
         critical_ff  <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == lhogs_pkg::RegGapOrder) gap_order_ff <= csr_pwdata[8:0];
         else critical_ff <= csr_pwdata;
      end
   end

   assign ram_wr = back_busy ? back_wr : front_wr;

   lhogs_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_sample(req_sample), .req_last_sample(req_last_sample),
      .back_busy(back_busy), .job_pop(job_pop), .job(job), .ram_wr(front_wr)
   );

   lhogs_ram #(.WIDTH(lhogs_pkg::SampleW), .DEPTH(lhogs_pkg::MaxSamples)) u_ram (
      .clock(clock),
      .wr_en(ram_wr.en), .wr_addr(ram_wr.addr), .wr_data(ram_wr.data),
      .rd_addr_a(rd_addr_a), .rd_data_a(rd_data_a),
      .rd_addr_b(rd_addr_b), .rd_data_b(rd_data_b)
   );

   lhogs_back u_back (
      .clock(clock), .reset(reset),
      .job(job), .job_pop(job_pop), .busy(back_busy),
      .gap_order(gap_order_ff), .critical_value(critical_ff),
      .ram_wr(back_wr),
      .rd_addr_a(rd_addr_a), .rd_addr_b(rd_addr_b),
      .rd_data_a(rd_data_a), .rd_data_b(rd_data_b),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_statistic(rsp_statistic), .rsp_reject(rsp_reject), .rsp_status(rsp_status)
   );

endmodule

>>> design/lhogs_ram.sv
// Generic RAM: one write port, two registered read ports.
module lhogs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

>>> design/lhogs_front.sv
// Front end: clamps and stores samples, hands a finished data set to the back end.
module lhogs_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [23:0]           req_sample,
   input  logic                         req_last_sample,
   input  logic                         back_busy,
   input  logic                         job_pop,
   output lhogs_pkg::job_type           job,
   output lhogs_pkg::ram_wr_type        ram_wr
);

   logic [lhogs_pkg::CountW-1:0]  count_ff, count_in;
   lhogs_pkg::job_type            job_ff, job_in;
   logic [lhogs_pkg::SampleW-1:0] clamped;
   logic                          accept;
   logic                          room;

   assign req_stall = job_ff.valid || back_busy;
   assign accept    = req_valid && !req_stall;
   assign room      = count_ff < lhogs_pkg::CountW'(lhogs_pkg::MaxSamples);

   always_comb begin
      if (req_sample[23])
         clamped = '0;
      else if (req_sample > 24'(lhogs_pkg::OneVal))
         clamped = lhogs_pkg::OneVal;
      else
         clamped = req_sample[lhogs_pkg::SampleW-1:0];
   end

   always_comb begin
      ram_wr.en   = accept && room;
      ram_wr.addr = count_ff[lhogs_pkg::AddrW-1:0];
      ram_wr.data = clamped;
      count_in    = count_ff;
      job_in      = job_ff;
      if (job_pop) job_in.valid = 1'b0;
      if (accept) begin
         if (room) count_in = count_ff + 1'b1;
         if (req_last_sample) begin
            job_in.valid = 1'b1;
            job_in.n     = room ? count_ff + 1'b1 : count_ff;
            count_in     = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         job_ff.valid <= 1'b0;
      end else begin
         count_ff     <= count_in;
         job_ff.valid <= job_in.valid;
      end
      job_ff.n <= job_in.n;
   end

   assign job = job_ff;

endmodule

>>> design/lhogs_back.sv
// Back end: sorts the stored set, sums the logs of the order-m gaps, drives results.
module lhogs_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lhogs_pkg::job_type            job,
   output logic                          job_pop,
   output logic                          busy,
   input  logic [8:0]                    gap_order,
   input  logic [31:0]                   critical_value,
   output lhogs_pkg::ram_wr_type         ram_wr,
   output logic [lhogs_pkg::AddrW-1:0]   rd_addr_a,
   output logic [lhogs_pkg::AddrW-1:0]   rd_addr_b,
   input  logic [lhogs_pkg::SampleW-1:0] rd_data_a,
   input  logic [lhogs_pkg::SampleW-1:0] rd_data_b,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_statistic,
   output logic                          rsp_reject,
   output logic [1:0]                    rsp_status
);

   localparam int CW = lhogs_pkg::CountW;
   localparam int SW = lhogs_pkg::SampleW;
   localparam int XW = lhogs_pkg::XW;

   lhogs_pkg::back_state_type state_ff, state_in;
   logic [CW-1:0]   n_ff, n_in, m_ff, m_in, top_ff, top_in, i_ff, i_in, j_ff, j_in;
   logic [CW:0]     li_ff, li_in;
   logic [SW-1:0]   v_ff, v_in;
   logic [1:0]      status_ff, status_in;
   logic [31:0]     sum_ff, sum_in;
   logic [XW-1:0]   x_ff, x_in;
   logic [lhogs_pkg::LogFrac-1:0] frac_ff, frac_in;
   logic [lhogs_pkg::KW-1:0]      k_ff, k_in;
   logic [4:0]      cnt_ff, cnt_in;
   logic [63:0]     prod_ff, prod_in;
   logic            rv_ff, rv_in, rej_ff, rej_in;
   logic [31:0]     stat_ff, stat_in;
   logic [1:0]      rst_ff, rst_in;

   logic [CW-1:0]   m_eff;
   logic [CW+1:0]   hi_idx;
   logic [CW:0]     lo_idx;
   logic [SW-1:0]   hi_val, lo_val, gap, gap_fix;
   logic [61:0]     sq;
   logic [31:0]     sq_sh;
   logic [30:0]     mag;
   logic [21:0]     term;
   logic [32:0]     sum_wide;
   logic [31:0]     stat_now;

   assign m_eff    = (gap_order == 9'd0) ? CW'(1) : CW'(gap_order);
   assign hi_idx   = (CW+2)'(li_ff) + (CW+2)'(m_ff) - (CW+2)'(1);
   assign lo_idx   = li_ff - 1'b1;
   assign hi_val   = (hi_idx >= (CW+2)'(n_ff)) ? lhogs_pkg::OneVal : rd_data_a;
   assign lo_val   = (li_ff == '0) ? '0 : rd_data_b;
   assign gap      = hi_val - lo_val;
   assign gap_fix  = (gap == '0) ? SW'(1) : gap;
   assign sq       = {31'b0, x_ff} * {31'b0, x_ff};
   assign sq_sh    = sq[61:30];
   assign mag      = (k_ff >= lhogs_pkg::KW'(lhogs_pkg::FracBits)) ? '0 :
                     ((31'(lhogs_pkg::FracBits) - 31'(k_ff)) << lhogs_pkg::LogFrac)
                     - 31'(frac_ff);
   assign term     = 22'((prod_ff + (64'd1 << 41)) >> 42);
   assign sum_wide = {1'b0, sum_ff} + 33'(term);
   assign stat_now = 32'd0 - sum_ff;

   always_comb begin
      state_in  = state_ff;
      n_in = n_ff; m_in = m_ff; top_in = top_ff; i_in = i_ff; j_in = j_ff;
      li_in = li_ff; v_in = v_ff; status_in = status_ff; sum_in = sum_ff;
      x_in = x_ff; frac_in = frac_ff; k_in = k_ff; cnt_in = cnt_ff; prod_in = prod_ff;
      rv_in = rv_ff && rsp_stall;
      rej_in = rej_ff; stat_in = stat_ff; rst_in = rst_ff;
      job_pop   = 1'b0;
      ram_wr    = '0;
      rd_addr_a = '0;
      rd_addr_b = '0;
      case (state_ff)
         lhogs_pkg::ST_IDLE: begin
            if (job.valid) begin
               job_pop   = 1'b1;
               n_in      = job.n;
               m_in      = m_eff;
               top_in    = job.n + 1'b1 - m_eff;
               status_in = lhogs_pkg::StatusOk;
               sum_in    = '0;
               i_in      = CW'(1);
               if ((CW+1)'(m_eff) > (CW+1)'(job.n) + 1'b1) begin
                  status_in = lhogs_pkg::StatusOrder;
                  state_in  = lhogs_pkg::ST_FIN;
               end else if (job.n <= CW'(3)) begin
                  status_in = lhogs_pkg::StatusFew;
                  state_in  = lhogs_pkg::ST_FIN;
               end else begin
                  state_in = lhogs_pkg::ST_SRD;
               end
            end
         end
         lhogs_pkg::ST_SRD: begin
            rd_addr_a = i_ff[lhogs_pkg::AddrW-1:0];
            state_in  = lhogs_pkg::ST_SGET;
         end
         lhogs_pkg::ST_SGET: begin
            v_in     = rd_data_a;
            j_in     = i_ff;
            state_in = lhogs_pkg::ST_SRDJ;
         end
         lhogs_pkg::ST_SRDJ: begin
            rd_addr_a = lhogs_pkg::AddrW'(j_ff - 1'b1);
            state_in  = (j_ff == '0) ? lhogs_pkg::ST_SPUT : lhogs_pkg::ST_SCMP;
         end
         lhogs_pkg::ST_SCMP: begin
            if (rd_data_a > v_ff) begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = j_ff[lhogs_pkg::AddrW-1:0];
               ram_wr.data = rd_data_a;
               j_in        = j_ff - 1'b1;
               state_in    = lhogs_pkg::ST_SRDJ;
            end else begin
               state_in = lhogs_pkg::ST_SPUT;
            end
         end
         lhogs_pkg::ST_SPUT: begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = j_ff[lhogs_pkg::AddrW-1:0];
            ram_wr.data = v_ff;
            i_in        = i_ff + 1'b1;
            li_in       = '0;
            state_in    = (i_ff + 1'b1 == n_ff) ? lhogs_pkg::ST_LRD : lhogs_pkg::ST_SRD;
         end
         lhogs_pkg::ST_LRD: begin
            rd_addr_a = hi_idx[lhogs_pkg::AddrW-1:0];
            rd_addr_b = lo_idx[lhogs_pkg::AddrW-1:0];
            state_in  = lhogs_pkg::ST_LGAP;
         end
         lhogs_pkg::ST_LGAP: begin
            if (gap == '0) status_in = lhogs_pkg::StatusZeroGap;
            k_in     = lhogs_pkg::lead_one(gap_fix);
            x_in     = XW'({14'b0, gap_fix} << (5'd30 - lhogs_pkg::lead_one(gap_fix)));
            frac_in  = '0;
            cnt_in   = 5'(lhogs_pkg::LogFrac - 1);
            state_in = lhogs_pkg::ST_LSQ;
         end
         lhogs_pkg::ST_LSQ: begin
            // one squaring per cycle gives one fraction bit of log2
            frac_in = {frac_ff[lhogs_pkg::LogFrac-2:0], sq_sh[31]};
            x_in    = sq_sh[31] ? sq_sh[31:1] : sq_sh[30:0];
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) state_in = lhogs_pkg::ST_LMUL;
         end
         lhogs_pkg::ST_LMUL: begin
            prod_in  = {33'b0, mag} * {32'b0, lhogs_pkg::Ln2Q32};
            state_in = lhogs_pkg::ST_LACC;
         end
         lhogs_pkg::ST_LACC: begin
            sum_in   = (sum_wide > 33'h0_8000_0000) ? 32'h8000_0000 : sum_wide[31:0];
            li_in    = li_ff + 1'b1;
            state_in = ((CW+1)'(li_ff) == (CW+1)'(top_ff)) ? lhogs_pkg::ST_FIN
                                                           : lhogs_pkg::ST_LRD;
         end
         lhogs_pkg::ST_FIN: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               stat_in  = stat_now;
               rst_in   = status_ff;
               rej_in   = (status_ff == lhogs_pkg::StatusOk) &&
                          ($signed(stat_now) < $signed(critical_value));
               state_in = lhogs_pkg::ST_IDLE;
            end
         end
         default: state_in = lhogs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lhogs_pkg::ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      n_ff <= n_in; m_ff <= m_in; top_ff <= top_in; i_ff <= i_in; j_ff <= j_in;
      li_ff <= li_in; v_ff <= v_in; status_ff <= status_in; sum_ff <= sum_in;
      x_ff <= x_in; frac_ff <= frac_in; k_ff <= k_in; cnt_ff <= cnt_in;
      prod_ff <= prod_in; rej_ff <= rej_in; stat_ff <= stat_in; rst_ff <= rst_in;
   end

   assign busy          = (state_ff != lhogs_pkg::ST_IDLE);
   assign rsp_valid     = rv_ff;
   assign rsp_statistic = stat_ff;
   assign rsp_reject    = rej_ff;
   assign rsp_status    = rst_ff;

`ifndef SYNTHESIS
   a_zero_no_reject: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == lhogs_pkg::StatusZeroGap |-> !rsp_reject)
      else $error("reject raised with zero gap");
   a_err_zero_stat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lhogs_pkg::StatusOrder ||
                    rsp_status == lhogs_pkg::StatusFew) |-> rsp_statistic == 32'd0)
      else $error("nonzero statistic on error status");
   a_sort_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == lhogs_pkg::ST_SRD |-> i_ff < n_ff)
      else $error("sort index out of range");
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == lhogs_pkg::ST_IDLE)
      else $error("job taken while busy");
`endif

endmodule

>>> test/lhogs_checker.sv
// Checker for the order-m log-spacings block: register shadow, prediction and compare.
module lhogs_checker
   import lhogs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [23:0] req_sample,
   input  logic               req_last_sample,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_statistic,
   input  logic               rsp_reject,
   input  logic [1:0]         rsp_status,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [2:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   input  logic               csr_pready,
   output int                 fail_count,
   output int                 pending,
   output int                 results_seen
);

   typedef struct packed {
      logic signed [31:0] statistic;
      logic               reject;
      logic [1:0]         status;
   } verdict_type;

   verdict_type          verdict_q[$];
   logic [SampleW-1:0]   held[$];
   logic [8:0]           order_reg;
   logic signed [31:0]   crit_reg;

   assign pending = verdict_q.size();

   // -ln(q / 2^F) in Q.F, for 1 <= q <= 2^F
   function automatic logic [63:0] neg_ln(input logic [31:0] q);
      int          k;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] mag;
      logic [63:0] prod;
      k = 0;
      while (k < 31 && (q >> (k + 1)) != 0) k++;
      x = 64'(q) << (30 - k);
      frac = '0;
      for (int b = 0; b < LogFrac; b++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= 64'h8000_0000) begin
            frac = frac | 64'd1;
            x = x >> 1;
         end
      end
      if (k >= FracBits) return 64'd0;
      mag = (64'(FracBits - k) << LogFrac) - frac;
      prod = mag * 64'(Ln2Q32);
      return (prod + (64'd1 << (57 - FracBits))) >> (58 - FracBits);
   endfunction

   function automatic verdict_type spacing_verdict();
      verdict_type        r;
      logic [SampleW-1:0] srt[$];
      int                 n;
      int                 m;
      int                 hi_i;
      int                 lo_i;
      logic [31:0]        hi;
      logic [31:0]        lo;
      logic [31:0]        g;
      logic [63:0]        sum;
      r = '0;
      n = held.size();
      m = (order_reg == 0) ? 1 : int'(order_reg);
      if (m > n + 1) begin
         r.status = StatusOrder;
      end else if (n <= 3) begin
         r.status = StatusFew;
      end else begin
         srt = held;
         srt.sort();
         sum = '0;
         r.status = StatusOk;
         for (int i = 0; i <= n + 1 - m; i++) begin
            hi_i = i + m - 1;
            lo_i = i - 1;
            hi = (hi_i >= n) ? 32'(OneVal) : 32'(srt[hi_i]);
            lo = (lo_i < 0) ? 32'd0 : 32'(srt[lo_i]);
            g = hi - lo;
            if (g == 0) begin
               g = 1;
               r.status = StatusZeroGap;
            end
            sum = sum + neg_ln(g);
            if (sum > 64'h8000_0000) sum = 64'h8000_0000;
         end
         r.statistic = 32'(-sum);
         r.reject = (r.status == StatusOk) && (r.statistic < crit_reg);
      end
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
      fail_count++;
   endtask

   always @(posedge clock) begin
      logic [SampleW-1:0] v;
      verdict_type        want;
      if (reset) begin
         verdict_q.delete();
         held.delete();
         order_reg <= 9'd2;
         crit_reg <= '0;
         fail_count = 0;
         results_seen = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == RegCritical) crit_reg <= csr_pwdata;
            else order_reg <= csr_pwdata[8:0];
         end
         if (req_valid && !req_stall) begin
            if (req_sample[23]) v = '0;
            else if (req_sample > 24'(OneVal)) v = OneVal;
            else v = req_sample[SampleW-1:0];
            if (held.size() < MaxSamples) held.push_back(v);
            if (req_last_sample) begin
               verdict_q.push_back(spacing_verdict());
               held.delete();
            end
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
               report("unexpected word", rsp_statistic, '0);
            end else begin
               want = verdict_q.pop_front();
               if (rsp_statistic !== want.statistic)
                  report("statistic", rsp_statistic, want.statistic);
               if (rsp_reject !== want.reject)
                  report("reject", 32'(rsp_reject), 32'(want.reject));
               if (rsp_status !== want.status)
                  report("status", 32'(rsp_status), 32'(want.status));
            end
         end
      end
   end

endmodule

>>> test/tb_top.sv
// Testbench top: stimulus, register setup and verdict for the log-spacings block.
module tb_top;
   import lhogs_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [23:0] req_sample;
   logic               req_last_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_statistic;
   logic               rsp_reject;
   logic [1:0]         rsp_status;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [2:0]         csr_paddr;
   logic [31:0]        csr_pwdata;
   logic [31:0]        csr_prdata;
   logic               csr_pready;
   int                 fail_count;
   int                 pending;
   int                 results_seen;
   int                 items_sent;
   int                 burst_left;
   logic               stall_busy;

   log_high_order_gap_statistic u_top (.*);

   lhogs_checker u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // receiver: quiet stretches alternate with busy stretches of random stalls
   initial begin
      rsp_stall = 1'b0;
      stall_busy = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 150) == 0) stall_busy <= ~stall_busy;
         rsp_stall <= stall_busy && ($urandom_range(0, 2) != 0);
      end
   end

   initial begin
      #(8 * 4_000_000);
      $display("log_high_order_gap_statistic regression: fail");
      $finish;
   end

   task automatic csr_write(input logic reg_idx, input logic [31:0] data);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {reg_idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic send_word(input logic [23:0] s, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      req_last_sample <= last;
      do @(posedge clock); while (req_stall);
      burst_left--;
      items_sent++;
   endtask

   function automatic logic [23:0] pick(input int mode, input logic [23:0] prev);
      case (mode)
         1: return ($urandom_range(0, 2) == 0) ? prev : 24'($urandom_range(0, 65536));
         2: return 24'($urandom);
         3: return $urandom_range(0, 1) ? 24'($urandom_range(0, 8))
                                        : 24'($urandom_range(65528, 65536));
         default: return 24'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic send_set(input int n, input int mode);
      logic [23:0] s;
      s = 24'h008000;
      for (int i = 0; i < n; i++) begin
         s = pick(mode, s);
         send_word(s, i == n - 1);
      end
   endtask

   // the word just sent was taken at this edge; drop valid so it is not taken again
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (40) @(posedge clock);
   endtask

   task automatic send_fixed(input logic [23:0] a, input logic [23:0] b,
                             input logic [23:0] c, input logic [23:0] d);
      send_word(a, 1'b0);
      send_word(b, 1'b0);
      send_word(c, 1'b0);
      send_word(d, 1'b1);
   endtask

   initial begin
      logic [8:0]  order;
      logic [31:0] crit;
      req_valid = 1'b0;
      req_sample = '0;
      req_last_sample = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      items_sent = 0;
      burst_left = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset settings: extremes, clamping, duplicates, too few samples
      send_fixed(24'h800000, 24'h7FFFFF, 24'h000000, 24'h010000);
      send_fixed(24'h004000, 24'h004000, 24'h004000, 24'h00C000);
      send_word(24'h001234, 1'b0);
      send_word(24'h00F000, 1'b1);
      send_word(24'hFFFFFF, 1'b1);
      drain();
      csr_write(RegGapOrder, 32'd5);
      csr_write(RegCritical, 32'h7FFF_FFFF);
      send_fixed(24'h001000, 24'h002000, 24'h00A000, 24'h00E000);
      send_set(4, 0);
      drain();
      csr_write(RegGapOrder, 32'd0);
      send_set(6, 0);
      send_set(5, 3);
      drain();

      for (int ph = 0; ph < 12; ph++) begin
         case (ph % 6)
            0: order = 9'd1;
            1: order = 9'd2;
            2: order = 9'd3;
            3: order = 9'($urandom_range(4, 12));
            4: order = $urandom_range(0, 1) ? 9'd257 : 9'd511;
            default: order = 9'($urandom_range(0, 6));
         endcase
         case (ph % 4)
            0: crit = 32'h8000_0000;
            1: crit = 32'h7FFF_FFFF;
            2: crit = 32'd0;
            default: crit = -32'($urandom_range(0, 40 << 16));
         endcase
         csr_write(RegGapOrder, 32'(order));
         csr_write(RegCritical, crit);
         if (ph == 3 || ph == 9) send_set(256, ph == 3 ? 0 : 1);
         if (ph == 7) send_set(270, 0);
         while (items_sent < 90 * (ph + 1) + 20) begin
            case ($urandom_range(0, 9))
               0, 1: send_set($urandom_range(4, 16), 1);
               2:    send_set($urandom_range(1, 16), 2);
               3:    send_set($urandom_range(4, 10), 3);
               4:    send_set($urandom_range(1, 4), 0);
               default: send_set($urandom_range(4, 16), 0);
            endcase
         end
         drain();
      end

      drain();
      $display("sent %0d sample words, checked %0d results across 15 register settings",
               items_sent, results_seen);
      if (fail_count == 0) $display("log_high_order_gap_statistic regression: pass");
      else $display("log_high_order_gap_statistic regression: fail");
      $finish;
   end

endmodule

>>> log_high_order_gap_statistic.f
design/lhogs_pkg.sv
design/lhogs_ram.sv
design/lhogs_front.sv
design/lhogs_back.sv
design/log_high_order_gap_statistic.sv
test/lhogs_checker.sv
test/tb_top.sv
